// ===== src/bgw_pkg.sv =====
// Shared types, constants and helpers for the bouncing-ball stepper.
`timescale 1ns / 1ps
`default_nettype none
package bgw_pkg;

  localparam int XY_W      = 32;  // position and velocity width
  localparam int STEP_FRAC = 16;  // fraction bits of time step and bounce factor
  localparam int DT_W      = 16;
  localparam int GRAV_W    = 31;
  localparam int BF_W      = 17;
  localparam int MAXB_W    = 8;
  localparam int WIN_W     = 12;
  localparam int RAD_W     = 10;
  localparam int TALLY_W   = 8;

  localparam int FRAC_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // Shared multiplier operands: signed 33-bit A, unsigned 17-bit B.
  localparam int MUL_A_W = XY_W + 1;
  localparam int MUL_B_W = BF_W;

  // Stream word widths, padded to whole bytes.
  localparam int IN_BITS  = DT_W + 4 * XY_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 4 * XY_W + TALLY_W + 1;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [GRAV_W-1:0] GRAV_RST = 31'd64225280;
  localparam logic [BF_W-1:0]   BF_RST   = 17'd52429;
  localparam logic [MAXB_W-1:0] MAXB_RST = 8'd3;
  localparam logic [WIN_W-1:0]  WIDTH_RST  = 12'd800;
  localparam logic [WIN_W-1:0]  HEIGHT_RST = 12'd600;
  localparam logic [RAD_W-1:0]  RAD_RST  = 10'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRAVITY = 3'd0,
    CFG_BOUNCE  = 3'd1,
    CFG_MAXB    = 3'd2,
    CFG_WIDTH   = 3'd3,
    CFG_HEIGHT  = 3'd4,
    CFG_RADIUS  = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GRAV,   // multiply gravity by dt
    S_VY,     // vy += g*dt, multiply vx by dt
    S_PX,     // px += vx*dt, multiply vy by dt
    S_PY,     // py += vy*dt
    S_CHKX,   // left/right wall test, multiply -vx by bounce factor
    S_BNCX,   // right wall velocity
    S_CHKY,   // floor/top test, multiply -vy by bounce factor
    S_BNCY,   // floor velocity
    S_TOPY,   // top wall velocity
    S_DONE
  } state_e;

  typedef struct packed {
    logic                       fire;
    logic signed [MUL_A_W-1:0]  a;
    logic        [MUL_B_W-1:0]  b;
  } mac_req_t;

  // Absolute value; the most negative value saturates to the largest positive one.
  function automatic logic signed [XY_W-1:0] abs_sat(input logic signed [XY_W-1:0] v);
    if (v == {1'b1, {(XY_W-1){1'b0}}}) begin
      abs_sat = {1'b0, {(XY_W-1){1'b1}}};
    end else if (v[XY_W-1]) begin
      abs_sat = -v;
    end else begin
      abs_sat = v;
    end
  endfunction

endpackage
`default_nettype wire

// ===== src/bgw_mac.sv =====
// Shared multiply unit with registered product and a saturating floor-shift add.
`timescale 1ns / 1ps
`default_nettype none
module bgw_mac
  import bgw_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire mac_req_t                 req_i,
  input  wire logic signed [XY_W-1:0]   addend_i,
  output logic signed [XY_W-1:0]        sum_o
);

  localparam int PROD_W = MUL_A_W + MUL_B_W + 1;
  localparam int SHR_W  = PROD_W - STEP_FRAC;
  localparam int SUM_W  = SHR_W + 1;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [SHR_W-1:0]  shr;
  logic signed [SUM_W-1:0]  sum_w;
  logic        [SUM_W-XY_W:0] hi;

  always_ff @(posedge clk_i) begin
    if (req_i.fire) begin
      prod_q <= req_i.a * $signed({1'b0, req_i.b});
    end
  end

  // Dropping the low bits of a two's complement product rounds toward minus infinity.
  assign shr   = prod_q[PROD_W-1:STEP_FRAC];
  assign sum_w = {shr[SHR_W-1], shr} + {{(SUM_W-XY_W){addend_i[XY_W-1]}}, addend_i};
  assign hi    = sum_w[SUM_W-1:XY_W-1];

  always_comb begin
    if (&hi || ~|hi) begin
      sum_o = sum_w[XY_W-1:0];
    end else if (sum_w[SUM_W-1]) begin
      sum_o = {1'b1, {(XY_W-1){1'b0}}};
    end else begin
      sum_o = {1'b0, {(XY_W-1){1'b1}}};
    end
  end

endmodule
`default_nettype wire

// ===== src/ball_gravity_wall_bounce_step.sv =====
// A tick word walks nine sequencer steps, five of which use the single shared multiplier, then
// S_DONE; a launch word goes straight to S_DONE. A new word is taken only once the last one has
// left S_DONE, which waits while the output register holds a word not yet taken.
// A finished word waits in the output register while the next input is taken.
// Reset clears position, velocity and bounce count to zero, loads the register
// defaults and leaves no result pending.
`timescale 1ns / 1ps
`default_nettype none
module ball_gravity_wall_bounce_step
  import bgw_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Configuration writes
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // Input stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_W-1:0]       s_axis_tdata,  // time_step, launch_x, launch_y, launch_vx, launch_vy
  input  wire logic                  s_axis_tuser,  // cmd
  // Output stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_W-1:0]           m_axis_tdata   // out_x, out_y, out_vx, out_vy, floor_bounces,
                                                    // bounces_exhausted, zero pad
);

  // Wide signed width for wall positions; holds window << FRAC_BITS and a 32-bit position.
  localparam int CW = (FRAC_BITS + WIN_W + 2 > XY_W + 2) ? FRAC_BITS + WIN_W + 2 : XY_W + 2;

  state_e state_q, state_d;

  logic [GRAV_W-1:0]  grav_q;
  logic [BF_W-1:0]    bf_q;
  logic [MAXB_W-1:0]  maxb_q;
  logic [WIN_W-1:0]   width_q;
  logic [WIN_W-1:0]   height_q;
  logic [RAD_W-1:0]   rad_q;

  logic signed [XY_W-1:0] px_q, py_q, vx_q, vy_q;
  logic [TALLY_W-1:0]     tally_q;
  logic [DT_W-1:0]        dt_q;
  logic                   rx_q, fy_q, ty_q;
  logic                   m_valid_q;
  logic [OUT_W-1:0]       out_q;

  mac_req_t               mac_req;
  logic signed [XY_W-1:0] mac_addend;
  logic signed [XY_W-1:0] mac_sum;

  logic signed [CW-1:0]   r_w, w_w, h_w, wr_w, hr_w, px_w, py_w;
  logic                   hit_left, hit_right, hit_floor, hit_top;
  logic signed [XY_W-1:0] vx1;
  logic signed [MUL_A_W-1:0] vx1_ext, vy_ext, vx_ext;
  logic                   in_acc, out_load;

  function automatic logic signed [XY_W-1:0] sat_w(input logic signed [CW-1:0] v);
    logic [CW-XY_W:0] hi;
    hi = v[CW-1:XY_W-1];
    if (&hi || ~|hi) begin
      sat_w = v[XY_W-1:0];
    end else if (v[CW-1]) begin
      sat_w = {1'b1, {(XY_W-1){1'b0}}};
    end else begin
      sat_w = {1'b0, {(XY_W-1){1'b1}}};
    end
  endfunction

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == S_DONE) && (!m_valid_q || m_axis_tready);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;

  // Wall geometry in the position format.
  assign r_w  = $signed({{(CW-RAD_W-FRAC_BITS){1'b0}}, rad_q, {FRAC_BITS{1'b0}}});
  assign w_w  = $signed({{(CW-WIN_W-FRAC_BITS){1'b0}}, width_q, {FRAC_BITS{1'b0}}});
  assign h_w  = $signed({{(CW-WIN_W-FRAC_BITS){1'b0}}, height_q, {FRAC_BITS{1'b0}}});
  assign wr_w = w_w - r_w;
  assign hr_w = h_w - r_w;
  assign px_w = {{(CW-XY_W){px_q[XY_W-1]}}, px_q};
  assign py_w = {{(CW-XY_W){py_q[XY_W-1]}}, py_q};

  assign hit_left  = px_w < r_w;
  assign hit_right = px_w > wr_w;
  assign hit_floor = py_w > hr_w;
  assign hit_top   = py_w < r_w;

  // The right wall acts on the velocity already reflected by the left wall.
  assign vx1     = hit_left ? abs_sat(vx_q) : vx_q;
  assign vx1_ext = {vx1[XY_W-1], vx1};
  assign vy_ext  = {vy_q[XY_W-1], vy_q};
  assign vx_ext  = {vx_q[XY_W-1], vx_q};

  // Operand selection for the shared multiplier.
  always_comb begin
    mac_req    = '0;
    mac_addend = '0;
    unique case (state_q)
      S_GRAV: begin
        mac_req.fire = 1'b1;
        mac_req.a    = $signed({2'b00, grav_q});
        mac_req.b    = {1'b0, dt_q};
      end
      S_VY: begin
        mac_req.fire = 1'b1;
        mac_req.a    = vx_ext;
        mac_req.b    = {1'b0, dt_q};
        mac_addend   = vy_q;
      end
      S_PX: begin
        mac_req.fire = 1'b1;
        mac_req.a    = vy_ext;
        mac_req.b    = {1'b0, dt_q};
        mac_addend   = px_q;
      end
      S_PY: begin
        mac_addend = py_q;
      end
      S_CHKX: begin
        mac_req.fire = 1'b1;
        mac_req.a    = -vx1_ext;
        mac_req.b    = bf_q;
      end
      S_CHKY: begin
        mac_req.fire = 1'b1;
        mac_req.a    = -vy_ext;
        mac_req.b    = bf_q;
      end
      default: begin
        mac_req    = '0;
        mac_addend = '0;
      end
    endcase
  end

  bgw_mac u_mac (
    .clk_i    (clk_i),
    .req_i    (mac_req),
    .addend_i (mac_addend),
    .sum_o    (mac_sum)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = s_axis_tuser ? S_DONE : S_GRAV;
        end
      end
      S_GRAV: state_d = S_VY;
      S_VY:   state_d = S_PX;
      S_PX:   state_d = S_PY;
      S_PY:   state_d = S_CHKX;
      S_CHKX: state_d = S_BNCX;
      S_BNCX: state_d = S_CHKY;
      S_CHKY: state_d = S_BNCY;
      S_BNCY: state_d = S_TOPY;
      S_TOPY: state_d = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q   <= GRAV_RST;
      bf_q     <= BF_RST;
      maxb_q   <= MAXB_RST;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      rad_q    <= RAD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GRAVITY: grav_q   <= cfg_data_i[GRAV_W-1:0];
        CFG_BOUNCE:  bf_q     <= cfg_data_i[BF_W-1:0];
        CFG_MAXB:    maxb_q   <= cfg_data_i[MAXB_W-1:0];
        CFG_WIDTH:   width_q  <= cfg_data_i[WIN_W-1:0];
        CFG_HEIGHT:  height_q <= cfg_data_i[WIN_W-1:0];
        CFG_RADIUS:  rad_q    <= cfg_data_i[RAD_W-1:0];
        default:     grav_q   <= grav_q;
      endcase
    end
  end

  // Ball state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q    <= '0;
      py_q    <= '0;
      vx_q    <= '0;
      vy_q    <= '0;
      tally_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && s_axis_tuser) begin
            px_q    <= s_axis_tdata[DT_W +: XY_W];
            py_q    <= s_axis_tdata[DT_W + XY_W +: XY_W];
            vx_q    <= s_axis_tdata[DT_W + 2*XY_W +: XY_W];
            vy_q    <= s_axis_tdata[DT_W + 3*XY_W +: XY_W];
            tally_q <= '0;
          end
        end
        S_VY: vy_q <= mac_sum;
        S_PX: px_q <= mac_sum;
        S_PY: py_q <= mac_sum;
        S_CHKX: begin
          vx_q <= vx1;
          if (hit_right) begin
            px_q <= sat_w(wr_w);
          end else if (hit_left) begin
            px_q <= sat_w(r_w);
          end
        end
        S_BNCX: begin
          if (rx_q) begin
            vx_q <= mac_sum;
          end
        end
        S_CHKY: begin
          if (hit_top) begin
            py_q <= sat_w(r_w);
          end else if (hit_floor) begin
            py_q <= sat_w(hr_w);
          end
          if (hit_floor && !(&tally_q)) begin
            tally_q <= tally_q + 1'b1;
          end
        end
        S_BNCY: begin
          if (fy_q) begin
            vy_q <= mac_sum;
          end
        end
        S_TOPY: begin
          if (ty_q) begin
            vy_q <= abs_sat(vy_q);
          end
        end
        default: tally_q <= tally_q;
      endcase
    end
  end

  // Step operands and wall flags carried between sequencer steps, and the output word.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dt_q <= s_axis_tdata[DT_W-1:0];
    end
    if (state_q == S_CHKX) begin
      rx_q <= hit_right;
    end
    if (state_q == S_CHKY) begin
      fy_q <= hit_floor;
      ty_q <= hit_top;
    end
    if (out_load) begin
      out_q <= {{(OUT_W-OUT_BITS){1'b0}}, (tally_q >= maxb_q), tally_q,
                vy_q, vx_q, py_q, px_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_tick_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !s_axis_tuser) |=> (state_q == S_GRAV))
    else $error("accepted tick word did not start the sequencer");

  a_launch_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> (state_q == S_DONE && tally_q == '0))
    else $error("launch word did not clear the bounce count");

  a_tally_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> (tally_q >= $past(tally_q)))
    else $error("bounce count dropped without a launch");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == S_DONE))
    else $error("result word appeared outside the final step");

  a_exhausted_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (out_q[4*XY_W + TALLY_W] == (out_q[4*XY_W +: TALLY_W] >= maxb_q)))
    else $error("exhausted flag disagrees with the bounce count");
`endif

endmodule
`default_nettype wire
